// ===== src/bkb_pkg.sv =====
package bkb_pkg;

  localparam int KEY_W    = 37;
  localparam int DATA_W   = 16;
  localparam int CNT_W    = 7;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Search token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic   active;
    logic   found;
    entry_t hit;
  } token_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] fill;
    logic             ins_we;
    entry_t           ins;
  } cell_ctl_t;

endpackage

// ===== src/bkb_cell.sv =====
module bkb_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bkb_pkg::cell_ctl_t ctl_i,
  input  bkb_pkg::token_t    tok_i,
  output bkb_pkg::token_t    tok_o,
  input  bkb_pkg::entry_t    next_i,
  output bkb_pkg::entry_t    entry_o
);
  import bkb_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  token_t tok_r;
  token_t tok_nxt;
  logic   slot_valid;
  logic   slot_last;
  logic   slot_more;
  logic   slot_tail;
  logic   hit;

  assign slot_valid = INDEX < int'(ctl_i.fill);
  assign slot_last  = (INDEX + 1) == int'(ctl_i.fill);
  assign slot_more  = (INDEX + 1) < int'(ctl_i.fill);
  assign slot_tail  = INDEX == int'(ctl_i.fill);

  always_comb begin
    unique case (ctl_i.op)
      OP_QUERY, OP_REMOVE: hit = slot_valid && (entry_r.key == ctl_i.key);
      OP_POP:              hit = slot_last;
      default:             hit = 1'b0;
    endcase
  end

  // The first matching cell captures its record into the token; later
  // cells pass it along untouched.
  always_comb begin
    tok_nxt = tok_i;
    if (!tok_i.found) begin
      tok_nxt.found = tok_i.active && hit;
      tok_nxt.hit   = (tok_i.active && hit) ? entry_r : '0;
    end
  end

  // Behind a found token in a keyed removal each cell takes its upper
  // neighbor's record, which closes the gap one slot per cycle.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.ins_we && slot_tail) begin
      entry_nxt = ctl_i.ins;
    end else if (tok_r.active && tok_r.found && (ctl_i.op == OP_REMOVE) && slot_more) begin
      entry_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
    tok_r.found <= tok_nxt.found;
    tok_r.hit   <= tok_nxt.hit;
  end

  assign tok_o   = tok_r;
  assign entry_o = entry_r;

endmodule

// ===== src/bounded_keyed_bag_table.sv =====
// Bounded keyed bag table: up to TABLE_DEPTH records of a 37-bit key and a
// 16-bit data word, held in insertion order in a chain of cells, slot 0 the
// oldest. Each request is one operation: insert, query by key, remove newest
// or remove by key; each gives exactly one result. An insert is stored
// only while the entry count is below min(capacity, TABLE_DEPTH), so the
// entry count is at most TABLE_DEPTH. An insert's result is registered
// on acceptance and moves to the output register once the output is
// free. Every other operation sends a search token down the cell chain,
// one cell per cycle and always through all of it; after the registered
// start strobe and every cell register, its result is registered and
// moves to the output register the same way. A keyed removal closes the
// gap behind the token as it travels, so it costs no extra time. One
// request is worked on at a time; a new one is taken once the previous
// result is in the output register, while it still waits on the output.
// The capacity register may be written only while the block is idle.
module bounded_keyed_bag_table #(
  parameter int TABLE_DEPTH = bkb_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bkb_pkg::CNT_W-1:0]     cfg_capacity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bkb_pkg::OP_W-1:0]      in_operation,
  input  logic [bkb_pkg::KEY_W-1:0]     in_search_key,
  input  logic [bkb_pkg::DATA_W-1:0]    in_record_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bkb_pkg::STATUS_W-1:0]  out_status,
  output logic [bkb_pkg::KEY_W-1:0]     out_found_key,
  output logic [bkb_pkg::DATA_W-1:0]    out_found_data,
  output logic [bkb_pkg::CNT_W-1:0]     out_entry_count
);
  import bkb_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] cap_r;
  logic             start_r;
  status_t          res_status_r;
  entry_t           res_entry_r;

  logic             out_valid_r;
  status_t          out_status_r;
  entry_t           out_entry_r;
  logic [CNT_W-1:0] out_count_r;

  logic      accept;
  logic      room;
  logic      ins_req;
  logic      ins_we;
  logic      start_nxt;
  logic      scan_done;
  logic      load_out;
  cell_ctl_t ctl;
  token_t    tok_head;

  token_t tok_chain   [TABLE_DEPTH];
  entry_t entry_chain [TABLE_DEPTH];

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  assign accept  = in_valid && in_ready;
  assign ins_req = op_t'(in_operation) == OP_INSERT;
  // Room while below both the programmed capacity and the physical depth.
  assign room    = (fill_r < cap_r) && (int'(fill_r) < TABLE_DEPTH);

  // Next-state logic of the request sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = ins_req ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_chain[TABLE_DEPTH-1].active) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    scan_done = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready  = 1'b1;
      S_SCAN:   scan_done = tok_chain[TABLE_DEPTH-1].active;
      S_RESULT: load_out  = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign ins_we    = accept && ins_req && room;
  assign start_nxt = accept && !ins_req;

  // Every cell sees the same registered operation, key and fill count. The
  // insert strobe and record come straight from the accepted request so the
  // slot at the fill count is written in the acceptance cycle.
  assign ctl.op       = op_r;
  assign ctl.key      = key_r;
  assign ctl.fill     = fill_r;
  assign ctl.ins_we   = ins_we;
  assign ctl.ins.key  = in_search_key;
  assign ctl.ins.data = in_record_data;

  // A fresh token enters cell 0 for one cycle at the start of a search.
  assign tok_head.active = start_r;
  assign tok_head.found  = 1'b0;
  assign tok_head.hit    = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    token_t tok_in;
    entry_t next_entry;

    if (g == 0) begin : g_first
      assign tok_in = tok_head;
    end else begin : g_link
      assign tok_in = tok_chain[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entry_chain[g+1];
    end

    bkb_cell #(
      .INDEX(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .tok_i   (tok_in),
      .tok_o   (tok_chain[g]),
      .next_i  (next_entry),
      .entry_o (entry_chain[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      cap_r   <= CAPACITY_RESET;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      if (ins_we) begin
        fill_r <= fill_r + 7'd1;
      end else if (scan_done && tok_chain[TABLE_DEPTH-1].found
                   && ((op_r == OP_POP) || (op_r == OP_REMOVE))) begin
        fill_r <= fill_r - 7'd1;
      end
    end
  end

  // Request and pending-result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_operation);
      key_r <= in_search_key;
    end
    if (accept && ins_req) begin
      res_status_r <= room ? STAT_OK : STAT_FULL;
      res_entry_r  <= '0;
    end else if (scan_done) begin
      if (tok_chain[TABLE_DEPTH-1].found) begin
        res_status_r <= STAT_OK;
        res_entry_r  <= tok_chain[TABLE_DEPTH-1].hit;
      end else begin
        res_status_r <= STAT_MISS;
        res_entry_r  <= '0;
      end
    end
  end

  // Output register; the fill count has already settled when it loads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_count_r  <= fill_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_key   = out_entry_r.key;
  assign out_found_data  = out_entry_r.data;
  assign out_entry_count = out_count_r;

endmodule
